### sv/ecc_pkg.sv
package ecc_pkg;

  localparam int unsigned SLOTS     = 5;
  localparam int unsigned SLOT_W    = 3;
  localparam logic [2:0]  LAST_SLOT = 3'd4;

  localparam logic [15:0] TPS_RESET = 16'd1000;

  localparam logic [3:0] KEY_NINE = 4'd9;
  localparam logic [3:0] KEY_FIVE = 4'd5;
  localparam logic [3:0] KEY_A    = 4'd10;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_C    = 4'd12;
  localparam logic [3:0] KEY_D    = 4'd13;
  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [3:0] key_code;
  } ecc_event_t;

  // tens*10 + ones; tens slots hold at most 5, so the result fits 6 bits
  function automatic logic [5:0] two_digit(input logic [3:0] tens, input logic [3:0] ones);
    logic [6:0] sum;
    sum = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
    return sum[5:0];
  endfunction

endpackage

### sv/ecc_in_reg.sv
module ecc_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [3:0]          in_key_code,
  input  logic                ev_take,
  output logic                ev_valid,
  output ecc_pkg::ecc_event_t ev
);

  logic                valid_r;
  ecc_pkg::ecc_event_t ev_r;

  // holding a transaction that the core cannot take yet
  assign in_stall = valid_r && !ev_take;
  assign ev_valid = valid_r;
  assign ev       = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ev_r.cmd      <= in_cmd;
      ev_r.key_code <= in_key_code;
    end
  end

endmodule

### sv/ecc_core.sv
module ecc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                ev_valid,
  input  ecc_pkg::ecc_event_t ev,
  output logic                ev_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_mode,
  output logic                out_lamp_on,
  output logic [3:0]          out_shown_hours,
  output logic [5:0]          out_shown_minutes,
  output logic [5:0]          out_shown_seconds,
  output logic [2:0]          out_cursor_slot,
  output logic                out_done_alert
);

  typedef enum logic [2:0] {
    M_SET   = 3'd0,
    M_IDLE  = 3'd1,
    M_RUN   = 3'd2,
    M_PAUSE = 3'd3,
    M_DONE  = 3'd4
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] tps_r;
  logic [15:0] div_r, div_nxt;
  logic [3:0]  pre_h_r, pre_h_nxt;
  logic [5:0]  pre_m_r, pre_m_nxt, pre_s_r, pre_s_nxt;
  logic [3:0]  rem_h_r, rem_h_nxt;
  logic [5:0]  rem_m_r, rem_m_nxt, rem_s_r, rem_s_nxt;
  logic [3:0]  dig_r   [ecc_pkg::SLOTS];
  logic [3:0]  dig_nxt [ecc_pkg::SLOTS];
  logic [ecc_pkg::SLOTS-1:0] filled_r, filled_nxt;
  logic [ecc_pkg::SLOT_W-1:0] cur_r, cur_nxt;

  logic        out_valid_r;
  logic [2:0]  o_mode_r;
  logic        o_lamp_r, o_done_r;
  logic [3:0]  o_h_r, o_h_nxt;
  logic [5:0]  o_m_r, o_m_nxt, o_s_r, o_s_nxt;
  logic [2:0]  o_cur_r, o_cur_nxt;

  logic        fire;
  logic [16:0] div_inc;
  logic [3:0]  bh;
  logic [5:0]  bm, bs;

  assign ev_take = !out_valid_r || !out_stall;
  assign fire    = ev_valid && ev_take;

  assign out_valid         = out_valid_r;
  assign out_mode          = o_mode_r;
  assign out_lamp_on       = o_lamp_r;
  assign out_shown_hours   = o_h_r;
  assign out_shown_minutes = o_m_r;
  assign out_shown_seconds = o_s_r;
  assign out_cursor_slot   = o_cur_r;
  assign out_done_alert    = o_done_r;

  assign div_inc = {1'b0, div_r} + 17'd1;

  // one second off the remaining time, borrowing minutes then hours
  always_comb begin
    bh = rem_h_r;
    bm = rem_m_r;
    bs = rem_s_r;
    if (bm == 6'd0 && bs == 6'd0 && bh != 4'd0) begin
      bm = 6'd60;
      bh = bh - 4'd1;
    end
    if (bs == 6'd0 && bm != 6'd0) begin
      bs = 6'd60;
      bm = bm - 6'd1;
    end
    if (bs != 6'd0) begin
      bs = bs - 6'd1;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    div_nxt    = div_r;
    pre_h_nxt  = pre_h_r;
    pre_m_nxt  = pre_m_r;
    pre_s_nxt  = pre_s_r;
    rem_h_nxt  = rem_h_r;
    rem_m_nxt  = rem_m_r;
    rem_s_nxt  = rem_s_r;
    dig_nxt    = dig_r;
    filled_nxt = filled_r;
    cur_nxt    = cur_r;

    if (ev.cmd == ecc_pkg::CMD_TICK) begin
      if (mode_r == M_RUN) begin
        // a zero register needs no special case: any count reaches it
        if (div_inc >= {1'b0, tps_r}) begin
          div_nxt   = '0;
          rem_h_nxt = bh;
          rem_m_nxt = bm;
          rem_s_nxt = bs;
          if (bh == 4'd0 && bm == 6'd0 && bs == 6'd0) begin
            mode_nxt = M_DONE;
          end
        end else begin
          div_nxt = div_inc[15:0];
        end
      end
    end else begin
      unique case (mode_r)
        M_SET: begin
          if (ev.key_code <= ecc_pkg::KEY_NINE) begin
            if (!((cur_r == 3'd1 || cur_r == 3'd3) && ev.key_code > ecc_pkg::KEY_FIVE)) begin
              dig_nxt[cur_r]    = ev.key_code;
              filled_nxt[cur_r] = 1'b1;
              cur_nxt = (cur_r == ecc_pkg::LAST_SLOT) ? '0 : cur_r + 3'd1;
            end
          end else if (ev.key_code == ecc_pkg::KEY_HASH && (&filled_r)) begin
            pre_h_nxt = dig_r[0];
            pre_m_nxt = ecc_pkg::two_digit(dig_r[1], dig_r[2]);
            pre_s_nxt = ecc_pkg::two_digit(dig_r[3], dig_r[4]);
            mode_nxt  = M_IDLE;
          end
        end
        M_IDLE: begin
          if (ev.key_code == ecc_pkg::KEY_A) begin
            rem_h_nxt = pre_h_r;
            rem_m_nxt = pre_m_r;
            rem_s_nxt = pre_s_r;
            div_nxt   = '0;
            mode_nxt  = (pre_h_r == 4'd0 && pre_m_r == 6'd0 && pre_s_r == 6'd0) ?
                        M_DONE : M_RUN;
          end else if (ev.key_code == ecc_pkg::KEY_STAR) begin
            for (int k = 0; k < ecc_pkg::SLOTS; k++) begin
              dig_nxt[k] = '0;
            end
            filled_nxt = '0;
            cur_nxt    = '0;
            mode_nxt   = M_SET;
          end
        end
        M_RUN, M_PAUSE: begin
          if (ev.key_code == ecc_pkg::KEY_A) begin
            mode_nxt = M_RUN;
          end else if (ev.key_code == ecc_pkg::KEY_B) begin
            mode_nxt = M_PAUSE;
          end else if (ev.key_code == ecc_pkg::KEY_C) begin
            rem_h_nxt = '0;
            rem_m_nxt = '0;
            rem_s_nxt = '0;
            mode_nxt  = M_IDLE;
          end
        end
        M_DONE: begin
          if (ev.key_code == ecc_pkg::KEY_D) begin
            mode_nxt = M_IDLE;
          end
        end
        default: begin
          mode_nxt = M_SET;
        end
      endcase
    end
  end

  // display follows the updated state
  always_comb begin
    o_cur_nxt = '0;
    if (mode_nxt == M_SET) begin
      o_h_nxt   = dig_nxt[0];
      o_m_nxt   = ecc_pkg::two_digit(dig_nxt[1], dig_nxt[2]);
      o_s_nxt   = ecc_pkg::two_digit(dig_nxt[3], dig_nxt[4]);
      o_cur_nxt = cur_nxt;
    end else if (mode_nxt == M_IDLE) begin
      o_h_nxt = pre_h_nxt;
      o_m_nxt = pre_m_nxt;
      o_s_nxt = pre_s_nxt;
    end else begin
      o_h_nxt = rem_h_nxt;
      o_m_nxt = rem_m_nxt;
      o_s_nxt = rem_s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= ecc_pkg::TPS_RESET;
      mode_r      <= M_SET;
      div_r       <= '0;
      pre_h_r     <= '0;
      pre_m_r     <= '0;
      pre_s_r     <= '0;
      rem_h_r     <= '0;
      rem_m_r     <= '0;
      rem_s_r     <= '0;
      for (int k = 0; k < ecc_pkg::SLOTS; k++) begin
        dig_r[k] <= '0;
      end
      filled_r    <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end
      if (fire) begin
        mode_r   <= mode_nxt;
        div_r    <= div_nxt;
        pre_h_r  <= pre_h_nxt;
        pre_m_r  <= pre_m_nxt;
        pre_s_r  <= pre_s_nxt;
        rem_h_r  <= rem_h_nxt;
        rem_m_r  <= rem_m_nxt;
        rem_s_r  <= rem_s_nxt;
        dig_r    <= dig_nxt;
        filled_r <= filled_nxt;
        cur_r    <= cur_nxt;
      end
      if (ev_take) begin
        out_valid_r <= ev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_mode_r <= mode_nxt;
      o_lamp_r <= (mode_nxt == M_RUN);
      o_done_r <= (mode_nxt == M_DONE);
      o_h_r    <= o_h_nxt;
      o_m_r    <= o_m_nxt;
      o_s_r    <= o_s_nxt;
      o_cur_r  <= o_cur_nxt;
    end
  end

endmodule

### sv/exposure_countdown_controller_unit.sv
// Exposure countdown controller. Each transaction is one event, a timer tick or a key
// press, and yields exactly one result with the mode, lamp, displayed time, entry cursor
// and done alert after that event. One event is taken every clock unless out_stall holds the
// result register full. The event lands in the input register when it is accepted, and the
// update logic loads the result register from it once the result register is free, which
// raises out_valid. Both registers hold under stall so no transaction is lost.
// Ticks count only while running; cfg_wr_data sets the ticks per second (0 acts as 1)
// and should be written only while no transaction is in flight.
module exposure_countdown_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [3:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_mode,
  output logic        out_lamp_on,
  output logic [3:0]  out_shown_hours,
  output logic [5:0]  out_shown_minutes,
  output logic [5:0]  out_shown_seconds,
  output logic [2:0]  out_cursor_slot,
  output logic        out_done_alert
);

  logic                ev_valid;
  logic                ev_take;
  ecc_pkg::ecc_event_t ev;

  ecc_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_key_code (in_key_code),
    .ev_take     (ev_take),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  ecc_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .ev_valid          (ev_valid),
    .ev                (ev),
    .ev_take           (ev_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mode          (out_mode),
    .out_lamp_on       (out_lamp_on),
    .out_shown_hours   (out_shown_hours),
    .out_shown_minutes (out_shown_minutes),
    .out_shown_seconds (out_shown_seconds),
    .out_cursor_slot   (out_cursor_slot),
    .out_done_alert    (out_done_alert)
  );

endmodule
